[rtl/sdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_pkg: shared types for the streaming-aware replacement policy
// Holds the event codes and the control bundle that the update logic hands
// to the top level.
// ----------------------------------------------------------------------------
package sdr_pkg;

	typedef enum logic [1:0] {
		CMD_VICTIM = 2'd0,
		CMD_ACCESS = 2'd1,
		CMD_EVICT  = 2'd2,
		CMD_DECAY  = 2'd3
	} cmd_t;

	// Side effects of one event, applied when the item commits.
	typedef struct packed {
		logic row_we;   // write the set row back
		logic strm_we;  // write the stride detector entry back
		logic cnt_inc;  // raise the addressed signature counter
		logic cnt_dec;  // lower the addressed signature counter
		logic sel_inc;  // raise the dueling selector
		logic sel_dec;  // lower the dueling selector
		logic decay;    // lower every signature counter
	} upd_ctl_t;

	localparam logic [1:0] RRPV_MAX = 2'd3;

endpackage

[rtl/sdr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module sdr_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sdr_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_update: read-modify-write logic for one event
// Takes the set row and stride entry read from memory and produces the
// values to write back, the victim way and the counter side effects.
// ----------------------------------------------------------------------------
module sdr_update #(
	parameter int NUM_WAYS       = 16,
	parameter int SET_W          = 11,
	parameter int LEADER_SETS    = 64,
	parameter int SIGNATURE_BITS = 5,
	parameter int ADDRESS_BITS   = 48
) (
	input  logic [1:0]                              cmd,
	input  logic [SET_W-1:0]                        set_idx,
	input  logic [3:0]                              way,
	input  logic                                    hit,
	input  logic [SIGNATURE_BITS-1:0]               sig,
	input  logic [ADDRESS_BITS-1:0]                 addr,
	input  logic [NUM_WAYS*(2+SIGNATURE_BITS)-1:0]  row_rd,
	input  logic [2*ADDRESS_BITS+2:0]               strm_rd,
	input  logic [1:0]                              cnt_val,
	input  logic                                    sel_top,
	output logic [NUM_WAYS*(2+SIGNATURE_BITS)-1:0]  row_wr,
	output logic [2*ADDRESS_BITS+2:0]               strm_wr,
	output logic [SIGNATURE_BITS-1:0]               cnt_idx,
	output logic [3:0]                              victim,
	output sdr_pkg::upd_ctl_t                       ctl
);
	import sdr_pkg::*;

	localparam int WAY_W        = $clog2(NUM_WAYS);
	localparam int LEADER_LIMIT = 2 * (LEADER_SETS / 2);

	logic [NUM_WAYS-1:0][1:0]                rr, rr_n;
	logic [NUM_WAYS-1:0][SIGNATURE_BITS-1:0] sg, sg_n;
	logic [ADDRESS_BITS-1:0] prev;
	logic [ADDRESS_BITS:0]   stride, stride_n;
	logic [1:0]              sctr, sctr_n;
	logic                    stride_match;
	logic                    way_ok;
	logic [WAY_W-1:0]        wi;
	logic                    lead, srrip, brrip;
	logic                    has3, has2, has1;
	logic [1:0]              top, age, depth;
	logic [31:0]             vw;

	assign {sg, rr}             = row_rd;
	assign {sctr, stride, prev} = strm_rd;

	// Exact signed stride: the borrow of the widened subtract is the sign.
	assign stride_n     = {1'b0, addr} - {1'b0, prev};
	assign stride_match = (stride != '0) && (stride_n == stride);
	assign sctr_n       = stride_match ? ((sctr == 2'd3) ? 2'd3 : sctr + 2'd1)
	                                   : ((sctr == 2'd0) ? 2'd0 : sctr - 2'd1);
	assign strm_wr      = {sctr_n, stride_n, addr};

	assign way_ok = (32'(way) < NUM_WAYS);
	assign wi     = WAY_W'(way);
	assign lead   = (32'(set_idx) < LEADER_LIMIT);
	assign srrip  = lead && !set_idx[0];
	assign brrip  = lead && set_idx[0];
	assign depth  = srrip ? 2'd0 : (brrip ? 2'd2 : (sel_top ? 2'd0 : 2'd2));

	// An eviction adjusts the counter of the line's stored signature; every
	// other event addresses the counter of the incoming signature.
	assign cnt_idx = (cmd_t'(cmd) == CMD_EVICT) ? sg[wi] : sig;

	always_comb begin
		has3 = 1'b0;
		has2 = 1'b0;
		has1 = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			has3 = has3 | (rr[w] == 2'd3);
			has2 = has2 | (rr[w] == 2'd2);
			has1 = has1 | (rr[w] == 2'd1);
		end
		top = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
		age = RRPV_MAX - top;
		// The first way holding the largest value reaches 3 after aging.
		vw = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rr[w] == top) begin
				vw = 32'(w);
			end
		end
	end

	always_comb begin
		rr_n    = rr;
		sg_n    = sg;
		ctl     = '0;
		victim  = '0;
		unique case (cmd_t'(cmd))
			CMD_VICTIM: begin
				for (int w = 0; w < NUM_WAYS; w++) begin
					rr_n[w] = rr[w] + age;
				end
				ctl.row_we = (top != RRPV_MAX);
				victim     = vw[3:0];
			end
			CMD_ACCESS: begin
				if (way_ok) begin
					ctl.row_we = 1'b1;
					if (hit) begin
						rr_n[wi]    = 2'd0;
						ctl.cnt_inc = 1'b1;
					end else begin
						ctl.strm_we = 1'b1;
						sg_n[wi]    = sig;
						if ((sctr_n >= 2'd2) || (cnt_val == 2'd0)) begin
							rr_n[wi] = RRPV_MAX;
						end else begin
							rr_n[wi] = depth;
						end
					end
				end
			end
			CMD_EVICT: begin
				if (way_ok && (rr[wi] == RRPV_MAX)) begin
					ctl.cnt_dec = 1'b1;
					ctl.sel_inc = srrip;
					ctl.sel_dec = brrip;
				end
			end
			CMD_DECAY: begin
				ctl.decay = 1'b1;
			end
		endcase
	end

	assign row_wr = {sg_n, rr_n};

endmodule

[rtl/ship_drrip_stream_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_drrip_stream_replacement: last-level cache replacement policy
// RRIP victim selection with signature-based outcome counters, a per-set
// stride detector for streaming misses and set dueling for fill depth.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                                            | Direction
//   --------+----------------------------------------------------+----------
//   input   | in_valid, in_stall, cmd, set_index, way_index,     | in
//           | pc, phys_addr, hit                                 |
//   output  | out_valid, out_stall, victim_way                   | out
//
// The accept edge launches the read of the set row and the stride entry from
// their RAMs; the commit edge in the execute state writes them back and loads
// the result register. One item is in flight at a time, so no forwarding is
// needed. After reset a clearing pass over all NUM_SETS sets loads both RAMs
// with their reset contents; in_stall stays high during it.
// A finished result waits in the output register while the next item is
// accepted; only if that register is still full when the next item finishes
// does the block hold its write-back until out_stall drops.
//
// Signature counters and the dueling selector live in flip-flops, since a
// decay tick lowers all counters at once.
module ship_drrip_stream_replacement #(
	parameter int NUM_SETS       = 2048,
	parameter int NUM_WAYS       = 16,
	parameter int LEADER_SETS    = 64,
	parameter int SELECTOR_BITS  = 10,
	parameter int SIGNATURE_BITS = 5,
	parameter int ADDRESS_BITS   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic [63:0] pc,
	input  logic [47:0] phys_addr,
	input  logic        hit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  victim_way
);
	import sdr_pkg::*;

	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int SIG_COUNT = 1 << SIGNATURE_BITS;
	localparam int ROW_W     = NUM_WAYS * (2 + SIGNATURE_BITS);
	localparam int STR_W     = 2 * ADDRESS_BITS + 3;
	localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
	localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
	// Reset row: every value at 3, every stored signature at 0.
	localparam logic [ROW_W-1:0] ROW_RESET =
		{{(NUM_WAYS * SIGNATURE_BITS){1'b0}}, {(2 * NUM_WAYS){1'b1}}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic             out_valid_q;
	logic [3:0]       victim_way_q;

	// Captured item.
	logic [1:0]                cmd_q;
	logic [SET_W-1:0]          set_q;
	logic [3:0]                way_q;
	logic                      hit_q;
	logic [SIGNATURE_BITS-1:0] sig_q;
	logic [ADDRESS_BITS-1:0]   addr_q;

	logic [1:0]               cnt_q [SIG_COUNT];
	logic [SELECTOR_BITS-1:0] sel_q;

	logic                      accept, finish, clearing;
	logic [SET_W-1:0]          set_in;
	logic [63:0]               pc_mix;
	logic [SIGNATURE_BITS-1:0] sig_in;
	logic [63:0]               addr_ext;
	logic [ADDRESS_BITS-1:0]   addr_in;

	logic             row_we, strm_we;
	logic [SET_W-1:0] waddr;
	logic [ROW_W-1:0] row_rd, row_wr, row_wdata;
	logic [STR_W-1:0] strm_rd, strm_wr, strm_wdata;
	logic [SIGNATURE_BITS-1:0] cnt_idx;
	logic [3:0]       victim_nx;
	upd_ctl_t         ctl;

	// Reduce the set number modulo NUM_SETS by conditional subtraction of
	// shifted copies; this is exact while the quotient of an 11-bit set is below 64.
	function automatic logic [SET_W-1:0] set_reduce(input logic [10:0] v);
		int r;
		r = int'(v);
		for (int k = 5; k >= 0; k--) begin
			if (r >= (NUM_SETS << k)) begin
				r = r - (NUM_SETS << k);
			end
		end
		return SET_W'(r);
	endfunction

	assign set_in   = set_reduce(set_index);
	assign pc_mix   = pc ^ (pc >> 5) ^ (pc >> 13);
	assign sig_in   = pc_mix[SIGNATURE_BITS-1:0];
	assign addr_ext = 64'(phys_addr);
	assign addr_in  = addr_ext[ADDRESS_BITS-1:0];

	assign clearing = (state_q == ST_CLEAR);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// The write-back commits only when the result register can take the result.
	assign finish   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	assign row_we     = clearing || (finish && ctl.row_we);
	assign strm_we    = clearing || (finish && ctl.strm_we);
	assign waddr      = clearing ? clr_q : set_q;
	assign row_wdata  = clearing ? ROW_RESET : row_wr;
	assign strm_wdata = clearing ? '0 : strm_wr;

	sdr_ram #(
		.DEPTH (NUM_SETS),
		.WIDTH (ROW_W),
		.AW    (SET_W)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (waddr),
		.wdata (row_wdata),
		.re    (accept),
		.raddr (set_in),
		.rdata (row_rd)
	);

	sdr_ram #(
		.DEPTH (NUM_SETS),
		.WIDTH (STR_W),
		.AW    (SET_W)
	) u_strm_ram (
		.clk   (clk),
		.we    (strm_we),
		.waddr (waddr),
		.wdata (strm_wdata),
		.re    (accept),
		.raddr (set_in),
		.rdata (strm_rd)
	);

	sdr_update #(
		.NUM_WAYS       (NUM_WAYS),
		.SET_W          (SET_W),
		.LEADER_SETS    (LEADER_SETS),
		.SIGNATURE_BITS (SIGNATURE_BITS),
		.ADDRESS_BITS   (ADDRESS_BITS)
	) u_update (
		.cmd     (cmd_q),
		.set_idx (set_q),
		.way     (way_q),
		.hit     (hit_q),
		.sig     (sig_q),
		.addr    (addr_q),
		.row_rd  (row_rd),
		.strm_rd (strm_rd),
		.cnt_val (cnt_q[cnt_idx]),
		.sel_top (sel_q[SELECTOR_BITS-1]),
		.row_wr  (row_wr),
		.strm_wr (strm_wr),
		.cnt_idx (cnt_idx),
		.victim  (victim_nx),
		.ctl     (ctl)
	);

	// Sequencer: clearing pass, then accept / execute, with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			victim_way_q <= '0;
		end else begin
			// A commit in the same cycle refills the register instead.
			if (out_valid_q && !out_stall && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (finish) begin
						state_q      <= ST_IDLE;
						out_valid_q  <= 1'b1;
						victim_way_q <= victim_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			set_q  <= set_in;
			way_q  <= way_index;
			hit_q  <= hit;
			sig_q  <= sig_in;
			addr_q <= addr_in;
		end
	end

	// Signature counters and the dueling selector, updated at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIG_COUNT; i++) begin
				cnt_q[i] <= 2'd1;
			end
			sel_q <= SEL_MID;
		end else if (finish) begin
			if (ctl.decay) begin
				for (int i = 0; i < SIG_COUNT; i++) begin
					if (cnt_q[i] != 2'd0) begin
						cnt_q[i] <= cnt_q[i] - 2'd1;
					end
				end
			end else if (ctl.cnt_inc && (cnt_q[cnt_idx] != 2'd3)) begin
				cnt_q[cnt_idx] <= cnt_q[cnt_idx] + 2'd1;
			end else if (ctl.cnt_dec && (cnt_q[cnt_idx] != 2'd0)) begin
				cnt_q[cnt_idx] <= cnt_q[cnt_idx] - 2'd1;
			end
			if (ctl.sel_inc && (sel_q != SEL_MAX)) begin
				sel_q <= sel_q + 1'b1;
			end else if (ctl.sel_dec && (sel_q != '0)) begin
				sel_q <= sel_q - 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_way_q;

	// An accepted item always moves on to the execute cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted item did not reach execute");

	// Memory writes happen only in the clearing pass or at commit.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!row_we && !strm_we))
		else $error("RAM written while idle");

	// Only a victim query yields a nonzero way.
	a_victim_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && (cmd_q != CMD_VICTIM)) |=> (victim_way_q == '0))
		else $error("nonzero victim for a non-query event");

	// The selector never moves both ways in one event.
	a_sel_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !(ctl.sel_inc && ctl.sel_dec))
		else $error("selector raised and lowered together");

	// No result appears during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid_q)
		else $error("result during clearing pass");

endmodule
